[rtl/psbw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel store blend package
// Shared widths, operation codes, the pixel type and the dimension clamp.
// ----------------------------------------------------------------------------
package psbw_pkg;

  localparam int COORD_W    = 16;
  localparam int DIM_W      = 9;
  localparam int CHAN_W     = 8;
  localparam int ALPHA_W    = 9;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int DIGIT_W    = 4;
  localparam int MOD_STEPS  = COORD_W / DIGIT_W;
  localparam int STEP_CNT_W = $clog2(MOD_STEPS);
  localparam int LIN_W      = 2 * DIM_W;
  localparam int PROD_W     = CHAN_W + ALPHA_W;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [DIM_W-1:0]   DIM_RESET = DIM_W'(256);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_WRITE = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_BLEND = MODE_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      r = DIM_W'(maxv);
    end
    return r;
  endfunction

endpackage

[rtl/pixel_store_blend_wrap_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel store blend core
// Reads, writes or alpha-blends one pixel of an RGB frame store per beat.
//
// Each input beat carries an operation, a wrap or clip flag, signed
// coordinates, a colour and an alpha; each yields exactly one output beat
// with the pixel read or stored and an in-range flag. Both streams use
// valid and stall. The width and height registers are written through the
// cfg port, which is always ready; the user writes them only while no beat
// is in progress, which the core does not enforce. One beat is processed
// at a time. A clipped in-range beat passes address multiply, memory read,
// blend products and write-back before the next acceptance; wrap mode
// first runs the remainder unit, which resolves 4 bits of each coordinate
// per cycle. A clipped out-of-range beat goes straight to the output stage.
// The result lands in an output register, so a stall there holds only the
// final write-back of the next beat, not its acceptance. After reset the
// store is swept to black, one entry per cycle over all MAX_WIDTH *
// MAX_HEIGHT entries, during which input beats are stalled.
// ----------------------------------------------------------------------------
module pixel_store_blend_wrap_core #(
  parameter int MAX_WIDTH  = psbw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = psbw_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [psbw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [psbw_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic        [psbw_pkg::MODE_W-1:0]    mode_i,
  input  logic                                  wrap_enable_i,
  input  logic signed [psbw_pkg::COORD_W-1:0]   x_coord_i,
  input  logic signed [psbw_pkg::COORD_W-1:0]   y_coord_i,
  input  logic        [psbw_pkg::CHAN_W-1:0]    red_in_i,
  input  logic        [psbw_pkg::CHAN_W-1:0]    green_in_i,
  input  logic        [psbw_pkg::CHAN_W-1:0]    blue_in_i,
  input  logic        [psbw_pkg::ALPHA_W-1:0]   alpha_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [psbw_pkg::CHAN_W-1:0]    red_out_o,
  output logic        [psbw_pkg::CHAN_W-1:0]    green_out_o,
  output logic        [psbw_pkg::CHAN_W-1:0]    blue_out_o,
  output logic                                  in_range_o
);

  localparam int StoreDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_ADDR,
    ST_READ,
    ST_MIX,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [psbw_pkg::DIM_W-1:0]      width_q;
  logic [psbw_pkg::DIM_W-1:0]      height_q;
  logic [psbw_pkg::MODE_W-1:0]     mode_q;
  logic                            skip_q;
  logic [psbw_pkg::DIM_W-1:0]      px_q;
  logic [psbw_pkg::DIM_W-1:0]      py_q;
  logic [AddrW-1:0]                addr_q;
  psbw_pkg::pixel_t                colour_q;
  logic [psbw_pkg::ALPHA_W-1:0]    alpha_q;
  logic                            out_valid_q;
  psbw_pkg::pixel_t                out_pix_q;
  logic                            in_range_q;

  logic [psbw_pkg::DIM_W-1:0]      w_eff;
  logic [psbw_pkg::DIM_W-1:0]      h_eff;
  logic                            accept;
  logic                            outside;
  logic                            out_free;
  logic                            finish;
  logic                            store_write;
  logic [psbw_pkg::LIN_W-1:0]      lin;
  logic                            clear_busy;
  psbw_pkg::pixel_t                rd_data;
  psbw_pkg::pixel_t                mix;
  psbw_pkg::pixel_t                result;
  logic                            x_done;
  logic                            y_done;
  logic [psbw_pkg::DIM_W-1:0]      x_wrap;
  logic [psbw_pkg::DIM_W-1:0]      y_wrap;

  assign cfg_ready_o = 1'b1;
  assign w_eff       = psbw_pkg::clamp_dim(width_q, MAX_WIDTH);
  assign h_eff       = psbw_pkg::clamp_dim(height_q, MAX_HEIGHT);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign outside     = x_coord_i[psbw_pkg::COORD_W-1] || y_coord_i[psbw_pkg::COORD_W-1]
                    || (unsigned'(x_coord_i) >= psbw_pkg::COORD_W'(w_eff))
                    || (unsigned'(y_coord_i) >= psbw_pkg::COORD_W'(h_eff));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign finish      = (state_q == ST_DONE) && out_free;
  assign store_write = finish && !skip_q
                    && ((mode_q == psbw_pkg::MODE_WRITE) || (mode_q == psbw_pkg::MODE_BLEND));
  assign lin         = psbw_pkg::LIN_W'(px_q) + psbw_pkg::LIN_W'(py_q) * psbw_pkg::LIN_W'(w_eff);

  always_comb begin
    case (mode_q)
      psbw_pkg::MODE_WRITE: result = colour_q;
      psbw_pkg::MODE_BLEND: result = mix;
      default:              result = rd_data;
    endcase
    if (skip_q) begin
      result = '0;
    end
  end

  psbw_mod u_mod_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && wrap_enable_i),
    .value_i   (x_coord_i),
    .modulus_i (w_eff),
    .done_o    (x_done),
    .result_o  (x_wrap)
  );

  psbw_mod u_mod_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && wrap_enable_i),
    .value_i   (y_coord_i),
    .modulus_i (h_eff),
    .done_o    (y_done),
    .result_o  (y_wrap)
  );

  psbw_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_busy_o (clear_busy),
    .rd_en_i      (state_q == ST_READ),
    .wr_en_i      (store_write),
    .addr_i       (addr_q),
    .wr_data_i    (result),
    .rd_data_o    (rd_data)
  );

  psbw_blend u_blend (
    .clk_i   (clk_i),
    .load_i  (state_q == ST_MIX),
    .new_i   (colour_q),
    .old_i   (rd_data),
    .alpha_i (alpha_q),
    .mix_o   (mix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      width_q     <= psbw_pkg::DIM_RESET;
      height_q    <= psbw_pkg::DIM_RESET;
      mode_q      <= psbw_pkg::MODE_READ;
      skip_q      <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      addr_q      <= '0;
      colour_q    <= '0;
      alpha_q     <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      in_range_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          psbw_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
          psbw_pkg::REG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (!clear_busy) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q   <= mode_i;
            colour_q <= '{red: red_in_i, green: green_in_i, blue: blue_in_i};
            alpha_q  <= (alpha_i > psbw_pkg::ALPHA_ONE) ? psbw_pkg::ALPHA_ONE : alpha_i;
            px_q     <= x_coord_i[psbw_pkg::DIM_W-1:0];
            py_q     <= y_coord_i[psbw_pkg::DIM_W-1:0];
            skip_q   <= 1'b0;
            if (wrap_enable_i) begin
              state_q <= ST_WRAP;
            end else if (outside) begin
              skip_q  <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_ADDR;
            end
          end
        end
        ST_WRAP: begin
          if (x_done) begin
            px_q    <= x_wrap;
            py_q    <= y_wrap;
            state_q <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          addr_q  <= AddrW'(lin);
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_MIX;
        end
        ST_MIX: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= result;
            in_range_q  <= !skip_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q.red;
  assign green_out_o = out_pix_q.green;
  assign blue_out_o  = out_pix_q.blue;
  assign in_range_o  = in_range_q;

  a_no_write_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !store_write)
    else $error("store written during clearing sweep");

  a_lanes_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done == y_done)
    else $error("wrap lanes finished apart");

  a_wrap_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done |-> ((x_wrap < w_eff) && (y_wrap < h_eff)))
    else $error("wrapped coordinate out of range");

  a_addr_in_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (int'(addr_q) < StoreDepth))
    else $error("pixel address beyond store");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("result retired into a stalled output register");

endmodule

[rtl/psbw_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate wrap unit
// Floored modulo of a signed coordinate by the image dimension, by restoring
// remainder over several bits of the magnitude per cycle.
// ----------------------------------------------------------------------------
module psbw_mod (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [psbw_pkg::COORD_W-1:0] value_i,
  input  logic        [psbw_pkg::DIM_W-1:0]   modulus_i,
  output logic                                done_o,
  output logic        [psbw_pkg::DIM_W-1:0]   result_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [psbw_pkg::STEP_CNT_W-1:0]   cnt_q;
  logic [psbw_pkg::COORD_W-1:0]      shreg_q;
  logic [psbw_pkg::DIM_W-1:0]        rem_q;
  logic [psbw_pkg::DIM_W-1:0]        n_q;
  logic                              neg_q;
  logic [psbw_pkg::COORD_W-1:0]      value_u;
  logic [psbw_pkg::COORD_W-1:0]      mag;
  logic [psbw_pkg::DIM_W-1:0]        rem_d;
  logic [psbw_pkg::DIM_W-1:0]        rem_fix;

  assign value_u = unsigned'(value_i);
  assign mag     = value_u[psbw_pkg::COORD_W-1] ? (~value_u + 1'b1) : value_u;

  always_comb begin
    logic [psbw_pkg::DIM_W:0] trial;
    rem_d = rem_q;
    for (int i = 0; i < psbw_pkg::DIGIT_W; i++) begin
      trial = {rem_d, shreg_q[psbw_pkg::COORD_W-1-i]};
      if (trial >= {1'b0, n_q}) begin
        trial = trial - {1'b0, n_q};
      end
      rem_d = trial[psbw_pkg::DIM_W-1:0];
    end
    rem_fix = (neg_q && (rem_d != '0)) ? (n_q - rem_d) : rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      shreg_q <= '0;
      rem_q   <= '0;
      n_q     <= '0;
      neg_q   <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i
             && (cnt_q == psbw_pkg::STEP_CNT_W'(psbw_pkg::MOD_STEPS - 1));
      if (start_i) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        shreg_q <= mag;
        rem_q   <= '0;
        n_q     <= modulus_i;
        neg_q   <= value_u[psbw_pkg::COORD_W-1];
      end else if (busy_q) begin
        shreg_q <= shreg_q << psbw_pkg::DIGIT_W;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == psbw_pkg::STEP_CNT_W'(psbw_pkg::MOD_STEPS - 1)) begin
          busy_q <= 1'b0;
          rem_q  <= rem_fix;
        end else begin
          rem_q <= rem_d;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = rem_q;

endmodule

[rtl/psbw_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha blend unit
// Registers the weighted products of new and old colour, then sums and
// scales them down by one in Q1.8.
// ----------------------------------------------------------------------------
module psbw_blend (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  psbw_pkg::pixel_t                 new_i,
  input  psbw_pkg::pixel_t                 old_i,
  input  logic [psbw_pkg::ALPHA_W-1:0]     alpha_i,
  output psbw_pkg::pixel_t                 mix_o
);

  logic [psbw_pkg::ALPHA_W-1:0] inv_alpha;
  logic [psbw_pkg::PROD_W-1:0]  pn_q [3];
  logic [psbw_pkg::PROD_W-1:0]  po_q [3];
  logic [psbw_pkg::CHAN_W-1:0]  nw   [3];
  logic [psbw_pkg::CHAN_W-1:0]  od   [3];
  logic [psbw_pkg::PROD_W-1:0]  sum  [3];

  assign inv_alpha = psbw_pkg::ALPHA_ONE - alpha_i;

  assign nw[0] = new_i.red;
  assign nw[1] = new_i.green;
  assign nw[2] = new_i.blue;
  assign od[0] = old_i.red;
  assign od[1] = old_i.green;
  assign od[2] = old_i.blue;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int c = 0; c < 3; c++) begin
        pn_q[c] <= psbw_pkg::PROD_W'(nw[c]) * psbw_pkg::PROD_W'(alpha_i);
        po_q[c] <= psbw_pkg::PROD_W'(od[c]) * psbw_pkg::PROD_W'(inv_alpha);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = pn_q[c] + po_q[c];
    end
  end

  assign mix_o.red   = sum[0][psbw_pkg::PROD_W-2 -: psbw_pkg::CHAN_W];
  assign mix_o.green = sum[1][psbw_pkg::PROD_W-2 -: psbw_pkg::CHAN_W];
  assign mix_o.blue  = sum[2][psbw_pkg::PROD_W-2 -: psbw_pkg::CHAN_W];

endmodule

[rtl/psbw_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel frame store
// Single-port synchronous memory with registered read data and a clearing
// sweep that writes black to every entry after reset.
// ----------------------------------------------------------------------------
module psbw_store #(
  parameter int MAX_WIDTH  = psbw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = psbw_pkg::DEF_MAX_HEIGHT,
  localparam int Depth     = MAX_WIDTH * MAX_HEIGHT,
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               clear_busy_o,
  input  logic               rd_en_i,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   addr_i,
  input  psbw_pkg::pixel_t   wr_data_i,
  output psbw_pkg::pixel_t   rd_data_o
);

  psbw_pkg::pixel_t mem [Depth];
  psbw_pkg::pixel_t rd_data_q;
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  psbw_pkg::pixel_t wdata;

  assign we    = clr_busy_q || wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign clear_busy_o = clr_busy_q;
  assign rd_data_o    = rd_data_q;

endmodule
